// File: rtl/longest_unique_run_length_unit_defines.svh
// Assertion macros for the RTL of the longest unique run length unit.
// The clocked macros expect signals named clk and rst_n in the using module.
`ifndef LONGEST_UNIQUE_RUN_LENGTH_UNIT_DEFINES_SVH
`define LONGEST_UNIQUE_RUN_LENGTH_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF

`define LURL_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define LURL_ASSERT_NEVER(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`else

`define LURL_ASSERT(label, prop, msg)

`define LURL_ASSERT_NEVER(label, expr, msg)

`endif

`endif

// File: rtl/lurl_pkg.sv
package lurl_pkg;

    localparam int CODE_W = 7;
    localparam int OUT_W  = 8;

    typedef struct packed {
        logic [CODE_W-1:0] char_code;
        logic              last_char;
    } char_item_t;

    typedef struct packed {
        logic [OUT_W-1:0] best_length;
        logic [OUT_W-1:0] window_length;
        logic             string_done;
    } run_item_t;

    typedef enum logic {
        ST_IDLE,
        ST_EVAL
    } state_t;

endpackage

// File: rtl/lurl_cell.sv
module lurl_cell #(
    parameter int LEN_W = 8,
    parameter int INDEX = 0
) (
    input  logic                        clk,
    input  logic                        shift,
    input  logic [lurl_pkg::CODE_W-1:0] char_in,
    input  logic [lurl_pkg::CODE_W-1:0] probe,
    input  logic [LEN_W-1:0]            win_len,
    output logic [lurl_pkg::CODE_W-1:0] char_out,
    output logic                        hit
);
    import lurl_pkg::*;

    logic [CODE_W-1:0] char_reg;

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            char_reg <= char_in;
        end
    end

    assign char_out = char_reg;
    assign hit      = (win_len > LEN_W'(INDEX)) && (char_reg == probe);

endmodule

// File: rtl/lurl_chain.sv
module lurl_chain #(
    parameter int NUM_CELLS = 128,
    parameter int LEN_W     = 8
) (
    input  logic                        clk,
    input  logic                        shift,
    input  logic [lurl_pkg::CODE_W-1:0] code,
    input  logic [LEN_W-1:0]            win_len,
    output logic [NUM_CELLS-1:0]        hit
);
    import lurl_pkg::*;

    logic [CODE_W-1:0] cell_char [NUM_CELLS];

    for (genvar i = 0; i < NUM_CELLS; i++)
    begin : g_cell
        logic [CODE_W-1:0] cell_in;

        if (i == 0)
        begin : g_head
            assign cell_in = code;
        end
        else
        begin : g_body
            assign cell_in = cell_char[i-1];
        end

        lurl_cell #(
            .LEN_W (LEN_W),
            .INDEX (i)
        ) u_cell (
            .clk      (clk),
            .shift    (shift),
            .char_in  (cell_in),
            .probe    (code),
            .win_len  (win_len),
            .char_out (cell_char[i]),
            .hit      (hit[i])
        );
    end

endmodule

// File: rtl/longest_unique_run_length_unit.sv
// Longest unique run length unit.
// Characters arrive on the char channel (char_valid, char_ready, char_data),
// one 7-bit code per transfer with a flag on the final character of a string.
// Each character yields exactly one transfer on the run channel (run_valid,
// run_ready, run_data) with the longest repeat-free run so far, the length of
// the repeat-free window ending at this character, and the end-of-string flag.
// The window lives in a row of cells, newest character first, that shifts by
// one cell per character; every cell compares its character with the new one
// in parallel, so a repeat trims the window in a single step.
// The character is captured into a register, and then, once the output register
// is free or being read, the cell compare, the hit encoder and the length update
// register the result and raise run_valid. char_ready is low from the capture
// until the result is registered, so no new character is taken meanwhile.
// After the final character of a string the window and the best length return
// to zero, and the next character starts a new string.
// Reset clears the window length, the best length and run_valid, and char_ready
// is high once reset ends; no clearing pass is needed. When the
// receiver stalls, the result is held in the output register, and one more
// character may be captured; its cell update waits for the held result's transfer.
module longest_unique_run_length_unit #(
    parameter int ALPHABET_SIZE = 128
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   char_valid,
    output logic                   char_ready,
    input  lurl_pkg::char_item_t   char_data,
    output logic                   run_valid,
    input  logic                   run_ready,
    output lurl_pkg::run_item_t    run_data
);
    import lurl_pkg::*;

    `include "longest_unique_run_length_unit_defines.svh"

    localparam int LEN_W = $clog2(ALPHABET_SIZE + 1);
    localparam int IDX_W = $clog2(ALPHABET_SIZE);
    localparam int NUM_CODES = 2 ** CODE_W;

    state_t state_reg;
    state_t state_next;

    logic [CODE_W-1:0] code_mod [NUM_CODES];
    logic [CODE_W-1:0] code_reg;
    logic              last_reg;

    logic [LEN_W-1:0] window_len_reg;
    logic [LEN_W-1:0] window_len_next;
    logic [LEN_W-1:0] best_len_reg;
    logic [LEN_W-1:0] best_len_next;

    logic              run_valid_reg;
    run_item_t         run_data_reg;

    logic                     eval_fire;
    logic [ALPHABET_SIZE-1:0] hit;
    logic                     any_hit;
    logic [IDX_W-1:0]         hit_idx;

    for (genvar v = 0; v < NUM_CODES; v++)
    begin : g_code_mod
        assign code_mod[v] = CODE_W'(v % ALPHABET_SIZE);
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (char_valid)
                begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                if (eval_fire)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        char_ready = 1'b0;
        eval_fire  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                char_ready = 1'b1;
            end
            ST_EVAL:
            begin
                eval_fire = !run_valid_reg || run_ready;
            end
            default:
            begin
                char_ready = 1'b0;
            end
        endcase
    end

    lurl_chain #(
        .NUM_CELLS (ALPHABET_SIZE),
        .LEN_W     (LEN_W)
    ) u_chain (
        .clk     (clk),
        .shift   (eval_fire),
        .code    (code_reg),
        .win_len (window_len_reg),
        .hit     (hit)
    );

    always_comb
    begin
        hit_idx = '0;
        for (int i = 0; i < ALPHABET_SIZE; i++)
        begin
            hit_idx = hit_idx | (hit[i] ? IDX_W'(i) : IDX_W'(0));
        end
    end

    assign any_hit = |hit;

    always_comb
    begin
        if (any_hit)
        begin
            window_len_next = LEN_W'(hit_idx) + LEN_W'(1);
        end
        else if (window_len_reg == LEN_W'(ALPHABET_SIZE))
        begin
            window_len_next = window_len_reg;
        end
        else
        begin
            window_len_next = window_len_reg + LEN_W'(1);
        end
        best_len_next = (window_len_next > best_len_reg) ? window_len_next : best_len_reg;
    end

    always_ff @(posedge clk)
    begin
        if (char_valid && char_ready)
        begin
            code_reg <= code_mod[char_data.char_code];
            last_reg <= char_data.last_char;
        end
        if (eval_fire)
        begin
            run_data_reg.best_length   <= OUT_W'(best_len_next);
            run_data_reg.window_length <= OUT_W'(window_len_next);
            run_data_reg.string_done   <= last_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            window_len_reg <= '0;
            best_len_reg   <= '0;
            run_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (eval_fire)
            begin
                run_valid_reg <= 1'b1;
                if (last_reg)
                begin
                    window_len_reg <= '0;
                    best_len_reg   <= '0;
                end
                else
                begin
                    window_len_reg <= window_len_next;
                    best_len_reg   <= best_len_next;
                end
            end
            else if (run_ready)
            begin
                run_valid_reg <= 1'b0;
            end
        end
    end

    assign run_valid = run_valid_reg;
    assign run_data  = run_data_reg;

    `LURL_ASSERT_NEVER(a_len_bound, window_len_reg > LEN_W'(ALPHABET_SIZE), "window too long")
    `LURL_ASSERT_NEVER(a_best_ge_len, best_len_reg < window_len_reg, "best below window")
    `LURL_ASSERT(a_single_hit, $onehot0(hit), "repeated character inside window")
    `LURL_ASSERT(a_result_source, $rose(run_valid_reg) |-> $past(eval_fire), "stray result")

endmodule
